@@ rtl/core/lkhc_pkg.sv @@
// Shared types and codes for the keyed handle cache.
package lkhc_pkg;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam int CAP_W = 7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] doc_key;
        logic [31:0] site_id;
        logic [31:0] doc_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_handle;
        logic        evicted;
        logic [63:0] evicted_key;
        logic        replaced;
    } rsp_t;

    typedef struct packed {
        logic bad;
        req_t req;
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_EXEC
    } back_state_t;

endpackage

@@ rtl/core/lkhc_front.sv @@
// Front end: accepts requests, flags bad ones (reserved type, zero key or site), and queues them for the back end.
module lkhc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lkhc_pkg::req_t req,
    output logic          q_valid,
    input  logic          q_pop,
    output lkhc_pkg::op_t q_head
);
    import lkhc_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    op_t        classified;

    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (count_reg != 2'd0);
    assign q_head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        classified.req = req;
        classified.bad = (req.req_type != REQ_LOOKUP && req.req_type != REQ_ADD &&
                          req.req_type != REQ_DELETE) ||
                         (req.doc_key == 64'd0) || (req.site_id == 32'd0);
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

@@ rtl/core/lkhc_back.sv @@
// Back end: key match, recency update, entry store and result register.
module lkhc_back #(
    parameter int DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  lkhc_pkg::op_t               q_head,
    input  logic [$clog2(DEPTH+1)-1:0]  capacity,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output lkhc_pkg::rsp_t              rsp
);
    import lkhc_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    back_state_t state_reg, state_next;

    op_t           op_reg;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [IW-1:0]    rank_reg [DEPTH];
    logic [IW-1:0]    rank_next [DEPTH];
    logic [63:0]      cell_key_reg [DEPTH];
    logic [31:0]      cell_site_reg [DEPTH];
    logic [CW-1:0]    occ_reg, occ_next;

    logic [31:0]      handle_mem [DEPTH];
    logic [63:0]      key_mem [DEPTH];
    logic [31:0]      handle_rd_reg;
    logic [63:0]      key_rd_reg;

    logic [DEPTH-1:0] hit_vec;
    logic [IW-1:0]    hit_idx_c, lru_idx_c, free_idx_c, hit_rank_c;
    logic             hit_c, lru_c, free_c;
    logic [IW-1:0]    hit_idx_reg, lru_idx_reg, free_idx_reg, hit_rank_reg;
    logic             hit_reg, lru_reg, free_reg;
    logic [IW-1:0]    last_rank;

    logic             commit;
    logic             do_touch, do_drop, do_ins, need_evict, ins_ok;
    logic [IW-1:0]    slot;
    rsp_t             rsp_c;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg, rsp_valid_next;

    // Parallel match, find first free entry and the least recent one.
    always_comb
    begin
        last_rank  = IW'(occ_reg - CW'(1));
        hit_idx_c  = '0;
        lru_idx_c  = '0;
        free_idx_c = '0;
        hit_rank_c = '0;
        hit_c      = 1'b0;
        lru_c      = 1'b0;
        free_c     = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_vec[i] = valid_reg[i] && cell_key_reg[i] == op_reg.req.doc_key &&
                         cell_site_reg[i] == op_reg.req.site_id;
            if (hit_vec[i])
            begin
                hit_c      = 1'b1;
                hit_idx_c  = IW'(i);
                hit_rank_c = rank_reg[i];
            end
            if (valid_reg[i] && rank_reg[i] == last_rank)
            begin
                lru_c     = 1'b1;
                lru_idx_c = IW'(i);
            end
        end
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_c     = 1'b1;
                free_idx_c = IW'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (q_valid) state_next = BK_MATCH;
            BK_MATCH: state_next = BK_EXEC;
            BK_EXEC:  if (!rsp_valid_reg || rsp_ready) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop  = (state_reg == BK_IDLE) && q_valid;
        commit = (state_reg == BK_EXEC) && (!rsp_valid_reg || rsp_ready);
    end

    // Decide the operation and the next store contents.
    always_comb
    begin
        do_touch   = !op_reg.bad && hit_reg &&
                     (op_reg.req.req_type == REQ_LOOKUP || op_reg.req.req_type == REQ_ADD);
        do_drop    = !op_reg.bad && hit_reg && op_reg.req.req_type == REQ_DELETE;
        do_ins     = !op_reg.bad && !hit_reg && op_reg.req.req_type == REQ_ADD;
        need_evict = do_ins && (occ_reg >= capacity || !free_reg) && lru_reg;
        ins_ok     = do_ins && (need_evict || free_reg);
        slot       = need_evict ? lru_idx_reg : free_idx_reg;

        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_touch)
            begin
                if (IW'(i) == hit_idx_reg)
                    rank_next[i] = '0;
                else if (valid_reg[i] && rank_reg[i] < hit_rank_reg)
                    rank_next[i] = rank_reg[i] + IW'(1);
            end
            else if (do_drop)
            begin
                if (IW'(i) == hit_idx_reg)
                    valid_next[i] = 1'b0;
                else if (valid_reg[i] && rank_reg[i] > hit_rank_reg)
                    rank_next[i] = rank_reg[i] - IW'(1);
            end
            else if (ins_ok)
            begin
                if (IW'(i) == slot)
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i])
                    rank_next[i] = rank_reg[i] + IW'(1);
            end
        end
        if (do_drop)
            occ_next = occ_reg - CW'(1);
        else if (ins_ok && !need_evict)
            occ_next = occ_reg + CW'(1);

        rsp_c.status       = op_reg.bad ? ST_BAD : (hit_reg ? ST_HIT : ST_MISS);
        rsp_c.found_handle = (!op_reg.bad && hit_reg && op_reg.req.req_type == REQ_LOOKUP) ?
                             handle_rd_reg : 32'd0;
        rsp_c.evicted      = need_evict;
        rsp_c.evicted_key  = need_evict ? key_rd_reg : 64'd0;
        rsp_c.replaced     = do_touch && op_reg.req.req_type == REQ_ADD &&
                             (handle_rd_reg != op_reg.req.doc_handle);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (commit)
            rsp_valid_next = 1'b1;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            op_reg <= q_head;
        if (state_reg == BK_MATCH)
        begin
            hit_reg      <= hit_c;
            hit_idx_reg  <= hit_idx_c;
            hit_rank_reg <= hit_rank_c;
            lru_reg      <= lru_c;
            lru_idx_reg  <= lru_idx_c;
            free_reg     <= free_c;
            free_idx_reg <= free_idx_c;
        end
        if (commit)
        begin
            rsp_reg <= rsp_c;
            for (int i = 0; i < DEPTH; i++)
                rank_reg[i] <= rank_next[i];
            if (ins_ok)
            begin
                cell_key_reg[slot]  <= op_reg.req.doc_key;
                cell_site_reg[slot] <= op_reg.req.site_id;
            end
        end
    end

    // Handle and key memories: read in the match cycle, written at commit.
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_MATCH)
        begin
            handle_rd_reg <= handle_mem[hit_idx_c];
            key_rd_reg    <= key_mem[lru_idx_c];
        end
        if (commit && (ins_ok || (do_touch && op_reg.req.req_type == REQ_ADD)))
        begin
            handle_mem[ins_ok ? slot : hit_idx_reg] <= op_reg.req.doc_handle;
        end
        if (commit && ins_ok)
        begin
            key_mem[slot] <= op_reg.req.doc_key;
        end
    end

endmodule

@@ rtl/core/lru_keyed_handle_cache.sv @@
// Top level of the keyed handle cache: capacity register and front/back hookup.
//
// Fully associative LRU cache keyed by (doc_key, site_id), returning a handle.
// Request channel req_valid/req_ready/req carries lookup, add and delete
// transactions; every transaction yields exactly one response on
// rsp_valid/rsp_ready/rsp, in order.
// A two-entry queue in the front end takes transactions while the back end
// works. The back end runs three steps per transaction (pop, parallel key
// match with memory read, commit) and pops the next transaction only after
// the commit of the current one.
// When the receiver stalls, the response is held in the output register; the
// back end waits at commit and the queue keeps filling until full.
// Reset clears all valid bits and occupancy at once and sets capacity to
// DEPTH; no clearing pass is needed. APB address 0 holds the capacity; writes
// with bits 6:0 of 0 or above DEPTH store DEPTH. Write it only while idle.
module lru_keyed_handle_cache #(
    parameter int DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lkhc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lkhc_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import lkhc_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    logic [CW-1:0]    cap_reg, cap_next;
    logic [CAP_W-1:0] wval;
    logic             cap_sel;
    logic             q_valid;
    logic             q_pop;
    op_t              q_head;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == 1'b0);
    assign wval    = pwdata[CAP_W-1:0];
    assign prdata  = cap_sel ? 32'(cap_reg) : 32'd0;

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && cap_sel)
        begin
            if (wval == '0 || 32'(wval) > 32'(DEPTH))
                cap_next = CW'(DEPTH);
            else
                cap_next = CW'(wval);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CW'(DEPTH);
        else
            cap_reg <= cap_next;
    end

    lkhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head)
    );

    lkhc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .capacity  (cap_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

@@ dv/tb_top.sv @@
// Testbench for the keyed handle cache: LRU predictor, driver, monitor and checks.
`timescale 1ns / 1ps

module tb_top;
    import lkhc_pkg::*;

    localparam int DEPTH = 64;
    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lru_keyed_handle_cache #(.DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the cache
    logic        sh_valid [DEPTH];
    logic [63:0] sh_key   [DEPTH];
    logic [31:0] sh_site  [DEPTH];
    logic [31:0] sh_handle[DEPTH];
    int unsigned sh_rank  [DEPTH];
    int unsigned sh_occ;
    int unsigned sh_cap;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors;
    int   cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   recv_hold;
    bit   req_acc;

    // keys drawn from a small pool so hits, replaces and evictions are common
    logic [63:0] key_pool [16];
    logic [31:0] site_pool[4];

    always #5 clk = ~clk;

    function automatic void make_recent(int e);
        int unsigned r;
        r = sh_rank[e];
        for (int i = 0; i < DEPTH; i++)
            if (sh_valid[i] && i != e && sh_rank[i] < r)
                sh_rank[i]++;
        sh_rank[e] = 0;
    endfunction

    function automatic void remove_entry(int e);
        int unsigned r;
        r = sh_rank[e];
        sh_valid[e] = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (sh_valid[i] && sh_rank[i] > r)
                sh_rank[i]--;
        if (sh_occ > 0)
            sh_occ--;
    endfunction

    function automatic rsp_t predict_cache(req_t r);
        rsp_t o;
        int   e;
        int   slot;
        int   lru;
        int unsigned best;
        o = '0;
        o.status = ST_BAD;
        if (r.req_type != REQ_RSVD && r.doc_key != 0 && r.site_id != 0)
        begin
            e = DEPTH;
            for (int i = DEPTH - 1; i >= 0; i--)
                if (sh_valid[i] && sh_key[i] == r.doc_key && sh_site[i] == r.site_id)
                    e = i;
            if (r.req_type == REQ_LOOKUP)
            begin
                if (e < DEPTH)
                begin
                    make_recent(e);
                    o.status = ST_HIT;
                    o.found_handle = sh_handle[e];
                end
                else
                    o.status = ST_MISS;
            end
            else if (r.req_type == REQ_DELETE)
            begin
                if (e < DEPTH)
                begin
                    remove_entry(e);
                    o.status = ST_HIT;
                end
                else
                    o.status = ST_MISS;
            end
            else if (e < DEPTH)
            begin
                o.status = ST_HIT;
                o.replaced = (sh_handle[e] != r.doc_handle);
                sh_handle[e] = r.doc_handle;
                make_recent(e);
            end
            else
            begin
                o.status = ST_MISS;
                slot = DEPTH;
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!sh_valid[i])
                        slot = i;
                if (sh_occ >= sh_cap || slot == DEPTH)
                begin
                    lru = DEPTH;
                    best = 0;
                    for (int i = 0; i < DEPTH; i++)
                        if (sh_valid[i] && (lru == DEPTH || sh_rank[i] >= best))
                        begin
                            lru = i;
                            best = sh_rank[i];
                        end
                    if (lru < DEPTH)
                    begin
                        o.evicted = 1'b1;
                        o.evicted_key = sh_key[lru];
                        remove_entry(lru);
                        slot = lru;
                    end
                end
                if (slot < DEPTH)
                begin
                    for (int i = 0; i < DEPTH; i++)
                        if (sh_valid[i])
                            sh_rank[i]++;
                    sh_valid[slot] = 1'b1;
                    sh_key[slot] = r.doc_key;
                    sh_site[slot] = r.site_id;
                    sh_handle[slot] = r.doc_handle;
                    sh_rank[slot] = 0;
                    sh_occ++;
                end
            end
        end
        return o;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int   k;
        r.req_type = $urandom_range(9) < 5 ? REQ_ADD :
                     ($urandom_range(1) ? REQ_LOOKUP : REQ_DELETE);
        if ($urandom_range(39) == 0)
            r.req_type = REQ_RSVD;
        k = $urandom_range(99);
        r.doc_key = key_pool[$urandom_range(15)];
        r.site_id = site_pool[$urandom_range(3)];
        if (k < 8)
            r.doc_key = {$urandom, $urandom};
        if (k >= 8 && k < 11)
            r.doc_key = 64'd0;
        if (k == 11)
            r.site_id = 32'd0;
        if (k == 12)
            r.site_id = $urandom;
        r.doc_handle = $urandom_range(3) == 0 ? $urandom : $urandom_range(3);
        return r;
    endfunction

    task automatic push_req(logic [1:0] t, logic [63:0] k, logic [31:0] s, logic [31:0] h);
        req_t r;
        r.req_type = t;
        r.doc_key = k;
        r.site_id = s;
        r.doc_handle = h;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_cap = (v[6:0] == 0 || v[6:0] > DEPTH) ? DEPTH : v[6:0];
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            pending_reqs.push_back(rand_req());
    endtask

    // Driver: advance only after the transaction was taken at the last rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_acc)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            if (recv_hold > 0)
            begin
                recv_hold <= recv_hold - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Predict on request acceptance, check on response acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            req_acc <= req_valid && req_ready;
            if (req_valid && req_ready)
                expected_rsps.push_back(predict_cache(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response %p", rsp);
                    errors = errors + 1;
                end
                else
                begin
                    rsp_t x;
                    x = expected_rsps.pop_front();
                    if (x.status != rsp.status)
                    begin
                        $error("status exp %0d got %0d", x.status, rsp.status);
                        errors = errors + 1;
                    end
                    if (x.found_handle != rsp.found_handle)
                    begin
                        $error("found_handle exp %h got %h", x.found_handle, rsp.found_handle);
                        errors = errors + 1;
                    end
                    if (x.evicted != rsp.evicted)
                    begin
                        $error("evicted exp %0d got %0d", x.evicted, rsp.evicted);
                        errors = errors + 1;
                    end
                    if (x.evicted_key != rsp.evicted_key)
                    begin
                        $error("evicted_key exp %h got %h", x.evicted_key, rsp.evicted_key);
                        errors = errors + 1;
                    end
                    if (x.replaced != rsp.replaced)
                    begin
                        $error("replaced exp %0d got %0d", x.replaced, rsp.replaced);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        recv_hold = 0;
        req_acc = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 48;
        sh_occ = 0;
        sh_cap = DEPTH;
        for (int i = 0; i < DEPTH; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_rank[i] = 0;
        end
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, $urandom} | 64'd1;
        key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[1] = 64'd1;
        for (int i = 0; i < 4; i++)
            site_pool[i] = $urandom | 32'd1;
        site_pool[0] = 32'hFFFF_FFFF;
        site_pool[1] = 32'd1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, each request type, bad keys, replace, delete miss
        write_capacity(32'd2);
        push_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_ADD, 64'd1, 32'd1, 32'd0);
        push_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
        push_req(REQ_ADD, 64'd2, 32'd1, 32'd7);
        push_req(REQ_LOOKUP, 64'd1, 32'd1, 32'd0);
        push_req(REQ_ADD, 64'd2, 32'd1, 32'd7);
        push_req(REQ_ADD, 64'd2, 32'd1, 32'd8);
        push_req(REQ_DELETE, 64'd2, 32'd1, 32'd0);
        push_req(REQ_DELETE, 64'd2, 32'd1, 32'd0);
        push_req(REQ_ADD, 64'd0, 32'd1, 32'd3);
        push_req(REQ_LOOKUP, 64'd1, 32'd0, 32'd3);
        push_req(REQ_DELETE, 64'd0, 32'd0, 32'd3);
        push_req(REQ_RSVD, 64'd1, 32'd1, 32'd3);
        push_req(REQ_ADD, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 32'hA5A5_5A5A);
        push_req(REQ_ADD, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 32'h5A5A_A5A5);
        wait_idle();
        write_capacity(32'd1);    // lowered below occupancy
        push_req(REQ_ADD, 64'd9, 32'd9, 32'd9);
        push_req(REQ_ADD, 64'd10, 32'd9, 32'd9);
        wait_idle();

        write_capacity(32'd0);
        run_random(250);
        wait_idle();
        write_capacity(32'd200);
        send_idle_pct = 48;
        recv_idle_pct = 34;
        run_random(250);
        wait_idle();
        write_capacity(32'd64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(40);
        recv_hold = 60;   // long receiver stall fills the block
        wait_idle();
        write_capacity(32'd4);
        run_random(230);
        wait_idle();
        write_capacity(32'd12);
        run_random(230);
        wait_idle();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
